/* rtl/mfat_pkg.sv */
// mfat_pkg: shared types, constants and helper functions of the motor feedback angle tracker
// used by the record memory, the scaler and the top level; no dependencies
`default_nettype none

package mfat_pkg;

  localparam int unsigned NumMotors = 4;
  localparam int unsigned MotorIdxW = (NumMotors > 1) ? $clog2(NumMotors) : 1;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 136;
  localparam int unsigned ApbAddrW = 3;

  localparam int unsigned TotalW = 37;

  localparam logic [10:0] BaseIdReset      = 11'd513;
  localparam logic [7:0]  CalibFramesReset = 8'd50;
  localparam logic [7:0]  FrameCountMax    = 8'd255;

  localparam logic signed [23:0] TurnMax = 24'sh7FFFFF;
  localparam logic signed [23:0] TurnMin = 24'sh800000;

  localparam logic signed [16:0] JumpHi = 17'sd4096;
  localparam logic signed [16:0] JumpLo = -17'sd4096;

  localparam logic signed [TotalW-1:0] TotalMax = {1'b0, {(TotalW-1){1'b1}}};
  localparam logic signed [TotalW-1:0] TotalMin = {1'b1, {(TotalW-1){1'b0}}};

  typedef enum logic {
    RegBaseId      = 1'b0,
    RegCalibFrames = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]         frame_count;
    logic [15:0]        last_position;
    logic [15:0]        zero_offset;
    logic signed [23:0] turn_count;
  } rec_t;

  typedef struct packed {
    logic                 we;
    logic [MotorIdxW-1:0] waddr;
    rec_t                 wdata;
  } rec_wr_t;

  // one unwrap step with saturating turn count
  function automatic logic signed [23:0] unwrap(input logic signed [23:0] turns,
                                                input logic [15:0] prev,
                                                input logic [15:0] now);
    logic signed [16:0] d;
    logic signed [23:0] r;
    d = $signed({1'b0, now}) - $signed({1'b0, prev});
    r = turns;
    if (d > JumpHi) begin
      if (turns != TurnMin) r = turns - 24'sd1;
    end else if (d < JumpLo) begin
      if (turns != TurnMax) r = turns + 24'sd1;
    end
    return r;
  endfunction

  // turns * 8192 + angle - offset, saturated to the total width
  function automatic logic [TotalW-1:0] calc_total(input logic signed [23:0] turns,
                                                   input logic [15:0] ang,
                                                   input logic [15:0] offs);
    logic signed [38:0] t;
    t = $signed({{2{turns[23]}}, turns, 13'd0}) + $signed({23'd0, ang})
        - $signed({23'd0, offs});
    if ((t[38:36] != 3'b000) && (t[38:36] != 3'b111)) begin
      return t[38] ? TotalMin : TotalMax;
    end
    return t[TotalW-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/mfat_rec_ram.sv */
// mfat_rec_ram: per-motor record memory, one write and one registered read port
// entries read as zero until first written; depends on mfat_pkg
`default_nettype none

module mfat_rec_ram (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  mfat_pkg::rec_wr_t        wr_i,
  input  wire                      re_i,
  input  wire [mfat_pkg::MotorIdxW-1:0] raddr_i,
  output mfat_pkg::rec_t           rdata_o
);
  import mfat_pkg::*;

  rec_t                 mem [NumMotors];
  logic [NumMotors-1:0] vld_q;
  rec_t                 rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.waddr] <= wr_i.wdata;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.waddr] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

/* rtl/mfat_scale.sv */
// mfat_scale: current field divided by -5, truncated toward zero
// reciprocal multiply; depends on mfat_pkg
`default_nettype none

module mfat_scale (
  input  wire signed [15:0] cur_i,
  output logic signed [13:0] scaled_o
);
  import mfat_pkg::*;

  logic [16:0] ext;
  logic [16:0] mag;
  logic [33:0] prod;
  logic [13:0] q;

  // |x| * 52429 >> 18 is exact floor(|x|/5) for |x| <= 32768
  always_comb begin
    ext  = {cur_i[15], cur_i};
    mag  = cur_i[15] ? (~ext + 17'd1) : ext;
    prod = 34'(mag) * 34'd52429;
    q    = prod[31:18];
    scaled_o = cur_i[15] ? $signed(q) : $signed(~q + 14'd1);
  end

endmodule

`default_nettype wire

/* rtl/motor_feedback_angle_tracker_top.sv */
// motor_feedback_angle_tracker_top: frame decode, record read-modify-write, result register
// input accept to result valid passes the stage 1 and result registers; one item per cycle
// sustained while the output is not stalled, with a registered record read and a bypass register
// asynchronous active-low reset clears all records, the shared record and the pipeline
// config registers reset to base_id 513 and calib_frames 50; depends on mfat_pkg
`default_nettype none

module motor_feedback_angle_tracker_top (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // frame_id[10:0], data_byte0..data_byte6 from bit 11 up, zero fill to 72
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire [mfat_pkg::InDataW-1:0]    s_axis_tdata,
  // motor_index, id_ok, calibrating, angle, measured, scaled_current, hall,
  // total, shared total from bit 0 up, zero fill to 136
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [mfat_pkg::OutDataW-1:0]  m_axis_tdata,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [mfat_pkg::ApbAddrW-1:0]   paddr,
  input  wire [31:0]                     pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import mfat_pkg::*;

  logic [10:0] base_id_q;
  logic [7:0]  calib_frames_q;
  reg_idx_e    reg_sel;

  // input decode
  logic [10:0]          in_fid;
  logic [11:0]          id_diff;
  logic                 in_ok;
  logic [MotorIdxW-1:0] in_idx;
  logic                 accept;

  // stage 1
  logic                 s1_valid_q;
  logic                 s1_ok_q;
  logic [MotorIdxW-1:0] s1_idx_q;
  logic [15:0]          s1_ang_q;
  logic [15:0]          s1_meas_q;
  logic [15:0]          s1_cur_q;
  logic [7:0]           s1_hall_q;
  logic                 s1_adv;

  rec_t                 rd_rec;
  rec_t                 cur_rec;
  rec_t                 new_rec;
  rec_wr_t              wr;
  logic                 byp_vld_q;
  logic [MotorIdxW-1:0] byp_idx_q;
  rec_t                 byp_rec_q;

  logic                 calib;
  logic [TotalW-1:0]    total;
  logic [TotalW-1:0]    shared_total;
  logic signed [23:0]   shared_turn_d;
  logic signed [23:0]   shared_turn_q;
  logic [15:0]          shared_last_q;
  logic signed [13:0]   scaled;

  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;
  logic [OutDataW-1:0]  out_data_d;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[2]);

  always_comb begin
    case (reg_sel)
      RegBaseId:      prdata = {21'd0, base_id_q};
      RegCalibFrames: prdata = {24'd0, calib_frames_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q      <= BaseIdReset;
      calib_frames_q <= CalibFramesReset;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        RegBaseId:      base_id_q      <= pwdata[10:0];
        RegCalibFrames: calib_frames_q <= pwdata[7:0];
        default:        ;
      endcase
    end
  end

  // identifier decode and record read
  assign in_fid  = s_axis_tdata[10:0];
  assign id_diff = {1'b0, in_fid} - {1'b0, base_id_q};
  assign in_ok   = (in_fid >= base_id_q) && (id_diff < 12'(NumMotors));
  assign in_idx  = id_diff[MotorIdxW-1:0];

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mfat_rec_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (rd_rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ok_q   <= in_ok;
      s1_idx_q  <= in_idx;
      s1_ang_q  <= {s_axis_tdata[18:11], s_axis_tdata[26:19]};
      s1_meas_q <= {s_axis_tdata[34:27], s_axis_tdata[42:35]};
      s1_cur_q  <= {s_axis_tdata[50:43], s_axis_tdata[58:51]};
      s1_hall_q <= s_axis_tdata[66:59];
    end
  end

  // record update, bypass covers a write to the same entry at the read edge
  always_comb begin
    cur_rec = (byp_vld_q && (byp_idx_q == s1_idx_q)) ? byp_rec_q : rd_rec;
    calib   = s1_ok_q && (cur_rec.frame_count <= calib_frames_q);
    new_rec = cur_rec;
    if (cur_rec.frame_count != FrameCountMax) begin
      new_rec.frame_count = cur_rec.frame_count + 8'd1;
    end
    new_rec.last_position = s1_ang_q;
    if (calib) begin
      new_rec.zero_offset = s1_ang_q;
    end else begin
      new_rec.turn_count = unwrap(cur_rec.turn_count, cur_rec.last_position, s1_ang_q);
    end
    if (s1_ok_q && !calib) begin
      total = calc_total(new_rec.turn_count, s1_ang_q, cur_rec.zero_offset);
    end else begin
      total = '0;
    end
    wr.we    = s1_adv && s1_ok_q;
    wr.waddr = s1_idx_q;
    wr.wdata = new_rec;
    shared_turn_d = unwrap(shared_turn_q, shared_last_q, s1_ang_q);
    shared_total  = calc_total(shared_turn_d, s1_ang_q, 16'd0);
  end

  mfat_scale u_scale (
    .cur_i    (s1_cur_q),
    .scaled_o (scaled)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_vld_q     <= 1'b0;
      shared_turn_q <= '0;
      shared_last_q <= '0;
    end else begin
      if (wr.we) begin
        byp_vld_q <= 1'b1;
      end
      if (s1_adv) begin
        shared_turn_q <= shared_turn_d;
        shared_last_q <= s1_ang_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.we) begin
      byp_idx_q <= wr.waddr;
      byp_rec_q <= wr.wdata;
    end
  end

  // result register
  always_comb begin
    out_data_d = {4'd0, shared_total, total, s1_hall_q, scaled, s1_meas_q, s1_ang_q,
                  calib, s1_ok_q, (s1_ok_q ? 2'(s1_idx_q) : 2'd0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

/* rtl/mfat_checker.sv */
// mfat_checker: port-level checks of the angle tracker top level
// bound to motor_feedback_angle_tracker_top; no package dependency
`default_nettype none

module mfat_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         s_axis_tvalid,
  input wire         s_axis_tready,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [135:0] m_axis_tdata
);

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed");

  // a new result follows an accepted input item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without input item");

  // unknown identifier gives no motor result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |->
      m_axis_tdata[1:0] == 2'd0 && !m_axis_tdata[3] && m_axis_tdata[94:58] == 37'd0)
    else $error("unknown identifier touched motor fields");

  // calibrating frame reports zero total for a known motor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2] && m_axis_tdata[94:58] == 37'd0)
    else $error("calibrating frame with nonzero total");

endmodule

bind motor_feedback_angle_tracker_top mfat_checker u_mfat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
